### hw/rtl/fqrr_pkg.sv
// shared types and constants for the four-queue round-robin drain
`timescale 1ns / 1ps
`default_nettype none

package fqrr_pkg;

  localparam int unsigned NumQueues       = 4;
  localparam int unsigned QueueDepthDflt  = 64;
  localparam int unsigned IdentCharsDflt  = 4;
  localparam int unsigned IdentWordW      = 32;

  typedef logic [1:0] queue_id_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } fqrr_op_e;

  typedef enum logic [1:0] {
    ST_PUSHED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } fqrr_status_e;

  // outcome of one item as decided by the queue control
  typedef struct packed {
    logic         push_ok;
    logic         pop_ok;
    fqrr_status_e status;
    queue_id_t    served;
    logic         all_empty;
  } fqrr_dec_t;

endpackage

`default_nettype wire

### hw/rtl/fqrr_entry_mem.sv
// entry storage for all four queues, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module fqrr_entry_mem
  import fqrr_pkg::*;
#(
  parameter int unsigned AddrW = 8,
  parameter int unsigned DataW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [DataW-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [DataW-1:0] rd_data_o
);

  localparam int unsigned Depth = 1 << AddrW;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hw/rtl/fqrr_queue_ctrl.sv
// head, tail and fill counters of the four queues and the round-robin pick
`timescale 1ns / 1ps
`default_nettype none

module fqrr_queue_ctrl
  import fqrr_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDflt,
  parameter int unsigned PtrW       = $clog2(QueueDepth),
  parameter int unsigned CntW       = $clog2(QueueDepth + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire fqrr_op_e        op_i,
  input  wire queue_id_t       sel_i,
  output fqrr_dec_t            dec_o,
  output logic [PtrW+1:0]      wr_addr_o,
  output logic [PtrW+1:0]      rd_addr_o
);

  logic [PtrW-1:0] head_q [NumQueues];
  logic [PtrW-1:0] head_d [NumQueues];
  logic [PtrW-1:0] tail_q [NumQueues];
  logic [PtrW-1:0] tail_d [NumQueues];
  logic [CntW-1:0] cnt_q  [NumQueues];
  logic [CntW-1:0] cnt_d  [NumQueues];
  queue_id_t       turn_q, turn_d;

  logic [NumQueues-1:0] nonempty;
  logic [NumQueues-1:0] full;
  logic [NumQueues-1:0] busy_after;
  logic                 found;
  queue_id_t            pick;
  queue_id_t            cand;
  logic                 push_ok;
  logic                 pop_ok;
  fqrr_status_e         status;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] idx);
    logic [PtrW-1:0] res;
    if (idx == PtrW'(QueueDepth - 1)) begin
      res = '0;
    end else begin
      res = idx + PtrW'(1);
    end
    return res;
  endfunction

  always_comb begin
    for (int i = 0; i < NumQueues; i++) begin
      nonempty[i] = (cnt_q[i] != '0);
      full[i]     = (cnt_q[i] == CntW'(QueueDepth));
    end
  end

  // first non-empty queue at or after the current turn
  always_comb begin
    found = 1'b0;
    pick  = '0;
    cand  = '0;
    for (int k = 0; k < NumQueues; k++) begin
      cand = turn_q + queue_id_t'(k);
      if (!found && nonempty[cand]) begin
        found = 1'b1;
        pick  = cand;
      end
    end
  end

  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    unique case (op_i)
      OP_PUSH: begin
        push_ok = !full[sel_i];
        status  = push_ok ? ST_PUSHED : ST_DROPPED;
      end
      OP_POP: begin
        pop_ok = found;
        status = found ? ST_POPPED : ST_EMPTY;
      end
      default: begin
        status = ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    turn_d = turn_q;
    if (fire_i && pop_ok) begin
      turn_d = pick + queue_id_t'(1);
    end
    for (int i = 0; i < NumQueues; i++) begin
      head_d[i]     = head_q[i];
      tail_d[i]     = tail_q[i];
      cnt_d[i]      = cnt_q[i];
      busy_after[i] = nonempty[i];
      if (push_ok && sel_i == queue_id_t'(i)) begin
        busy_after[i] = 1'b1;
        if (fire_i) begin
          tail_d[i] = wrap_inc(tail_q[i]);
          cnt_d[i]  = cnt_q[i] + CntW'(1);
        end
      end
      if (pop_ok && pick == queue_id_t'(i)) begin
        busy_after[i] = (cnt_q[i] != CntW'(1));
        if (fire_i) begin
          head_d[i] = wrap_inc(head_q[i]);
          cnt_d[i]  = cnt_q[i] - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_q <= '0;
      for (int i = 0; i < NumQueues; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      turn_q <= turn_d;
      for (int i = 0; i < NumQueues; i++) begin
        head_q[i] <= head_d[i];
        tail_q[i] <= tail_d[i];
        cnt_q[i]  <= cnt_d[i];
      end
    end
  end

  assign wr_addr_o = {sel_i, tail_q[sel_i]};
  assign rd_addr_o = {pick, head_q[pick]};

  assign dec_o.push_ok   = push_ok;
  assign dec_o.pop_ok    = pop_ok;
  assign dec_o.status    = status;
  assign dec_o.served    = pop_ok ? pick : queue_id_t'(0);
  assign dec_o.all_empty = (busy_after == '0);

endmodule

`default_nettype wire

### hw/rtl/four_queue_round_robin_drain.sv
// top level: four identifier queues drained in west, north, south, east rotation
// path: an accepted item is held in the input register, then its result and the registered
// entry read are captured in the result register once the output can take them
// throughput: one push or pop per cycle while the output is not stalled, using the single
// write and read port of the entry memory and the registered counter update
// reset: all queues empty and west served first; entries are undefined until pushed
`timescale 1ns / 1ps
`default_nettype none

module four_queue_round_robin_drain
  import fqrr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDflt,
  parameter int unsigned IDENT_CHARS = IdentCharsDflt
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // ident_word[31:0]
  input  wire logic [2:0]  s_axis_tuser_i,   // operation[0], queue_select[2:1]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // popped_ident[31:0]
  output logic [3:0]       m_axis_tuser_o,   // status_code[1:0], served_queue[3:2]
  output logic             m_axis_tlast_o    // all_empty_after
);

  localparam int unsigned PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AddrW = PtrW + 2;
  localparam int unsigned DataW = (IDENT_CHARS >= 4) ? IdentWordW : 8 * IDENT_CHARS;

  // input register
  logic                 in_valid_q;
  fqrr_op_e             in_op_q;
  queue_id_t            in_sel_q;
  logic [DataW-1:0]     in_word_q;

  // result register
  logic                 out_valid_q;
  fqrr_status_e         out_status_q;
  queue_id_t            out_served_q;
  logic                 out_empty_q;

  fqrr_dec_t            dec;
  logic [AddrW-1:0]     wr_addr;
  logic [AddrW-1:0]     rd_addr;
  logic [DataW-1:0]     rd_data;
  logic [IdentWordW-1:0] rd_ext;
  logic                 fire;
  logic                 in_xfer;

  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_op_q   <= fqrr_op_e'(s_axis_tuser_i[0]);
      in_sel_q  <= s_axis_tuser_i[2:1];
      in_word_q <= s_axis_tdata_i[DataW-1:0];
    end
  end

  fqrr_queue_ctrl #(
    .QueueDepth (QUEUE_DEPTH),
    .PtrW       (PtrW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .op_i      (in_op_q),
    .sel_i     (in_sel_q),
    .dec_o     (dec),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr)
  );

  fqrr_entry_mem #(
    .AddrW (AddrW),
    .DataW (DataW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (fire && dec.push_ok),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_word_q),
    .rd_en_i   (fire && dec.pop_ok),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= dec.status;
      out_served_q <= dec.served;
      out_empty_q  <= dec.all_empty;
    end
  end

  always_comb begin
    rd_ext            = '0;
    rd_ext[DataW-1:0] = rd_data;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = (out_status_q == ST_POPPED) ? rd_ext : '0;
  assign m_axis_tuser_o  = {out_served_q, out_status_q};
  assign m_axis_tlast_o  = out_empty_q;

endmodule

`default_nettype wire
